FILE: rtl/ts_start_code_indexer_macros.svh
// assertion macros for the start code indexer
`ifndef TS_START_CODE_INDEXER_MACROS_SVH
`define TS_START_CODE_INDEXER_MACROS_SVH
`ifndef SYNTHESIS
`define TSI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSI_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSI_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSI_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/tsi_pkg.sv
`default_nettype none
package tsi_pkg;
    localparam int OFFSET_BITS = 48;
    localparam int PTS_BITS = 33;
    localparam logic [8:0] NO_POS = 9'd511;
    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [1:0] REG_PID = 2'd0;
    localparam logic [1:0] REG_STREAM_TYPE = 2'd1;
    localparam logic [1:0] REG_PREFIX = 2'd2;
    localparam logic [1:0] ST_MPEG2 = 2'd0;
    localparam logic [1:0] ST_H264 = 2'd1;

    // a classified byte handed from the front to the scanner
    typedef struct packed {
        logic [7:0]             data;
        logic                   scan;   // scan window position p valid
        logic                   last;   // last scan position of packet
        logic [7:0]             pos;    // scan position p
        logic [OFFSET_BITS-1:0] pkt_start;
        logic                   pts_valid;
        logic [PTS_BITS-1:0]    pts;
        logic                   hdr4;
        logic [PTS_BITS-1:0]    held_pts;
        logic                   held_valid;
        logic                   win_shift;
    } t_work;

    typedef struct packed {
        logic                   entry_valid;
        logic [OFFSET_BITS-1:0] entry_offset;
        logic [63:0]            entry_data;
        logic                   point_valid;
        logic [OFFSET_BITS-1:0] point_offset;
        logic [PTS_BITS-1:0]    point_pts;
        logic [PTS_BITS-1:0]    recent_pts;
        logic                   recent_pts_valid;
    } t_result;
endpackage
`default_nettype wire

FILE: rtl/tsi_front.sv
`default_nettype none
module tsi_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [1:0]                      i_cfg_idx,
    input  wire logic [13:0]                     i_cfg_data,
    input  wire logic                            i_valid,
    input  wire logic [7:0]                      i_byte,
    input  wire logic [tsi_pkg::OFFSET_BITS-1:0] i_offset,
    input  wire logic                            i_more_set,
    output logic [1:0]                           o_stream_type,
    output tsi_pkg::t_work                       o_work
);
    logic [13:0] r_pid;
    logic [1:0]  r_stype;
    logic        r_prefix;
    logic [7:0]  r_pos;
    logic [2:0]  r_fill;
    logic [7:0]  r_h1, r_h3;
    logic [7:0]  r_h2;
    logic        r_taken;
    logic [8:0]  r_pay, r_pes;
    logic [7:0]  r_flags;
    logic [tsi_pkg::PTS_BITS-1:0] r_pts, r_held;
    logic        r_pts_v, r_held_v, r_more;
    logic [tsi_pkg::OFFSET_BITS-1:0] r_start;

    logic [7:0] n_pos;
    logic [2:0] n_fill;
    logic [7:0] n_h1, n_h2, n_h3;
    logic       n_taken, n_pts_v, n_held_v, n_more;
    logic [8:0] n_pay, n_pes;
    logic [7:0] n_flags;
    logic [tsi_pkg::PTS_BITS-1:0] n_pts, n_held;
    logic [tsi_pkg::OFFSET_BITS-1:0] n_start;
    logic [2:0] hdr;
    logic [7:0] psize, j;
    logic [8:0] d, v;
    logic [12:0] ppid;
    logic want, more_clr;
    tsi_pkg::t_work w;

    assign o_stream_type = r_stype;
    assign o_work = w;

    // a wanted packet header consumes a pending continuation request
    assign n_more = more_clr ? 1'b0 : (r_more | i_more_set);

    always_comb begin
        hdr = r_prefix ? 3'd4 : 3'd0;
        psize = r_prefix ? 8'd192 : 8'd188;
        n_pos = r_pos; n_fill = r_fill;
        n_h1 = r_h1; n_h2 = r_h2; n_h3 = r_h3;
        n_taken = r_taken; n_pay = r_pay; n_pes = r_pes; n_flags = r_flags;
        n_pts = r_pts; n_pts_v = r_pts_v; n_held = r_held; n_held_v = r_held_v;
        n_start = r_start;
        j = (r_pos >= {5'd0, hdr}) ? r_pos - {5'd0, hdr} : 8'd0;
        d = {1'b0, j} - r_pes;
        v = 9'd0; ppid = 13'd0; want = 1'b0; more_clr = 1'b0;
        w = '0;
        w.data = i_byte;
        w.hdr4 = r_prefix;
        if (i_valid) begin
            if (r_pos == 8'd0) begin
                if (i_byte == tsi_pkg::SYNC_BYTE && r_fill >= hdr) begin
                    n_start = i_offset - {{(tsi_pkg::OFFSET_BITS-3){1'b0}}, hdr};
                    n_pos = {5'd0, hdr} + 8'd1;
                    n_taken = 1'b0; n_pay = tsi_pkg::NO_POS; n_pes = tsi_pkg::NO_POS;
                    n_flags = 8'd0; n_pts = '0; n_pts_v = 1'b0;
                end else if (r_fill < 3'd4) begin
                    n_fill = r_fill + 3'd1;
                end
            end else begin
                w.win_shift = 1'b1;
                if (r_pos >= {5'd0, hdr} && j <= 8'd3) begin
                    if (j == 8'd1) n_h1 = i_byte;
                    if (j == 8'd2) n_h2 = i_byte;
                    if (j == 8'd3) begin
                        n_h3 = i_byte;
                        ppid = {r_h1[4:0], r_h2};
                        want = ({1'b0, ppid} == r_pid) &&
                               (r_more || r_h1[6] || r_stype == tsi_pkg::ST_MPEG2);
                        n_taken = 1'b0;
                        if (want) begin
                            more_clr = 1'b1;
                            if (i_byte[4] && i_byte[7:6] == 2'b00) begin
                                n_taken = 1'b1;
                                if (!i_byte[5]) begin
                                    if (r_h1[6]) begin
                                        n_pes = 9'd4; n_pay = tsi_pkg::NO_POS;
                                    end else n_pay = 9'd4;
                                end
                            end
                        end
                    end
                end else if (r_pos >= {5'd0, hdr} && r_taken) begin
                    if (j == 8'd4 && r_h3[5]) begin
                        v = 9'd5 + {1'b0, i_byte};
                        if (v > 9'd188) n_taken = 1'b0;
                        else if (r_h1[6]) begin
                            n_pes = v; n_pay = tsi_pkg::NO_POS;
                        end else n_pay = v;
                    end else if (r_h1[6] && r_pes <= 9'd187 && {1'b0, j} >= r_pes) begin
                        if (d <= 9'd1) begin
                            if (i_byte != 8'd0) n_taken = 1'b0;
                        end else if (d == 9'd2) begin
                            if (i_byte != 8'd1) n_taken = 1'b0;
                        end else if (d == 9'd7) begin
                            n_flags = i_byte;
                        end else if (d == 9'd8) begin
                            v = r_pes + 9'd9 + {1'b0, i_byte};
                            n_pay = (r_pes + 9'd9 + {1'b0, i_byte} < r_pes) ?
                                tsi_pkg::NO_POS : v;
                        end else if (d >= 9'd9 && d <= 9'd13 && r_flags[7]) begin
                            case (d[3:0])
                                4'd9:  n_pts = {i_byte[3:1], 30'd0};
                                4'd10: n_pts = r_pts | {3'd0, i_byte, 22'd0};
                                4'd11: n_pts = r_pts | {11'd0, i_byte[7:1], 15'd0};
                                4'd12: n_pts = r_pts | {18'd0, i_byte, 7'd0};
                                default: begin
                                    n_pts = r_pts | {26'd0, i_byte[7:1]};
                                    n_pts_v = 1'b1; n_held = n_pts; n_held_v = 1'b1;
                                end
                            endcase
                        end
                    end
                    if (n_taken && j >= 8'd5) begin
                        w.pos = j - 8'd5;
                        w.scan = ({1'b0, j - 8'd5} >= n_pay) && (j - 8'd5 <= 8'd182);
                        w.last = (j == 8'd187) && (n_pay <= 9'd183);
                    end
                end
                if (r_pos + 8'd1 >= psize) begin
                    n_pos = 8'd0; n_fill = 3'd0;
                end else n_pos = r_pos + 8'd1;
            end
        end
        // a write to the pid, stream type or prefix register restarts the sync search
        if (i_cfg_we && i_cfg_idx inside {tsi_pkg::REG_PID, tsi_pkg::REG_STREAM_TYPE,
                                          tsi_pkg::REG_PREFIX}) begin
            n_pos = 8'd0; n_fill = 3'd0;
        end
        w.pkt_start = n_start;
        w.pts = n_pts;
        w.pts_valid = n_pts_v;
        w.held_pts = n_held;
        w.held_valid = n_held_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid <= 14'd8192; r_stype <= 2'd2; r_prefix <= 1'b0;
            r_pos <= 8'd0; r_fill <= 3'd0; r_taken <= 1'b0;
            r_pay <= tsi_pkg::NO_POS; r_pes <= tsi_pkg::NO_POS; r_flags <= 8'd0;
            r_pts <= '0; r_pts_v <= 1'b0; r_held <= '0; r_held_v <= 1'b0;
            r_more <= 1'b0; r_start <= '0;
            r_h1 <= 8'd0; r_h2 <= 8'd0; r_h3 <= 8'd0;
        end else begin
            r_taken <= n_taken; r_pay <= n_pay; r_pes <= n_pes; r_flags <= n_flags;
            r_pts <= n_pts; r_pts_v <= n_pts_v; r_held <= n_held; r_held_v <= n_held_v;
            r_more <= n_more; r_start <= n_start;
            r_h1 <= n_h1; r_h2 <= n_h2; r_h3 <= n_h3;
            r_pos <= n_pos; r_fill <= n_fill;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tsi_pkg::REG_PID:         r_pid <= i_cfg_data;
                    tsi_pkg::REG_STREAM_TYPE: r_stype <= i_cfg_data[1:0];
                    tsi_pkg::REG_PREFIX:      r_prefix <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/tsi_scan.sv
`default_nettype none
// scanner: runs the six-byte window and forms result items
module tsi_scan (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [1:0]       i_stream_type,
    input  wire tsi_pkg::t_work   i_work,
    output logic                  o_more_set,
    output tsi_pkg::t_result      o_result
);
    logic [7:0] r_win [6];
    logic [7:0] s [6];
    tsi_pkg::t_result res;
    logic more;
    logic [tsi_pkg::OFFSET_BITS-1:0] base;

    always_comb begin
        for (int i = 0; i < 5; i++) s[i] = r_win[i+1];
        s[5] = i_work.data;
        res = '0;
        more = 1'b0;
        base = i_work.pkt_start + {{(tsi_pkg::OFFSET_BITS-3){1'b0}}, i_work.hdr4, 2'b00};
        res.recent_pts = i_work.held_pts;
        res.recent_pts_valid = i_work.held_valid;
        if (i_valid && i_work.scan && s[0] == 8'd0 && s[1] == 8'd0 && s[2] == 8'd1) begin
            if (i_stream_type == tsi_pkg::ST_MPEG2) begin
                if (s[3] == 8'h00 || s[3] == 8'hb3 || s[3] == 8'hb8) begin
                    if (s[3] == 8'hb3 && i_work.pts_valid) begin
                        res.point_valid = 1'b1;
                        res.point_offset = i_work.pkt_start;
                        res.point_pts = i_work.pts;
                    end
                    res.entry_valid = 1'b1;
                    res.entry_offset = base +
                        {{(tsi_pkg::OFFSET_BITS-8){1'b0}}, i_work.pos};
                    res.entry_data = {32'd0, 8'd0, s[5], s[4], s[3]};
                end
            end else if (i_stream_type == tsi_pkg::ST_H264) begin
                if (s[3] == 8'h09) begin
                    res.entry_valid = 1'b1;
                    res.entry_offset = base +
                        {{(tsi_pkg::OFFSET_BITS-8){1'b0}}, i_work.pos};
                    res.entry_data = {48'd0, s[4], s[3]};
                    if (s[4][7:5] == 3'd0 && i_work.pts_valid) begin
                        res.point_valid = 1'b1;
                        res.point_offset = i_work.pkt_start;
                        res.point_pts = i_work.pts;
                    end
                end
            end
        end
        if (i_valid && i_work.last && s[1] == 8'd0 && s[2] == 8'd0 && s[3] == 8'd1 &&
            i_stream_type == tsi_pkg::ST_MPEG2 &&
            (s[4] == 8'h00 || s[4] == 8'hb3 || s[4] == 8'hb8)) begin
            more = 1'b1;
            if (s[4] == 8'hb3 && i_work.pts_valid) begin
                res.point_valid = 1'b1;
                res.point_offset = i_work.pkt_start;
                res.point_pts = i_work.pts;
            end
        end
        if (res.entry_valid && i_work.pts_valid)
            res.entry_data = res.entry_data | {i_work.pts, 31'd0} | 64'h1000000;
    end

    assign o_result = res;
    assign o_more_set = more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_win[i] <= 8'd0;
        end else if (i_valid && i_work.win_shift) begin
            for (int i = 0; i < 5; i++) r_win[i] <= r_win[i+1];
            r_win[5] <= i_work.data;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/tsi_fifo.sv
`default_nettype none
`include "ts_start_code_indexer_macros.svh"
// two-entry result queue
module tsi_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tsi_pkg::t_result i_data,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output tsi_pkg::t_result     o_data
);
    tsi_pkg::t_result r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic do_pop;

    assign o_full = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data = r_mem[r_rp];
    assign do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

    `TSI_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full, "push while full")
    `TSI_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "count out of range")
    `TSI_ASSERT(a_ptr_match, i_clk, i_rst_n, (r_cnt != 2'd1) || (r_wp != r_rp), "pointers")
endmodule
`default_nettype wire

FILE: rtl/ts_start_code_indexer.sv
`default_nettype none
// channel   | handshake       | payload
// input     | i_push / o_full | i_stream_byte, i_byte_offset
// result    | o_empty / i_pop | entry, point, recent pts
// config    | i_cfg_we        | i_cfg_idx, i_cfg_data
// one byte per cycle while the queue is not full; each accepted byte gives one result
// the front parser and window scanner handle each byte combinationally; their state is registered
// a two-entry result queue decouples the sides; full stalls input
// synchronous active-low reset; no clearing pass
module ts_start_code_indexer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [1:0]                        i_cfg_idx,
    input  wire logic [13:0]                       i_cfg_data,
    input  wire logic                              i_push,
    output logic                                   o_full,
    input  wire logic [7:0]                        i_stream_byte,
    input  wire logic [tsi_pkg::OFFSET_BITS-1:0]   i_byte_offset,
    output logic                                   o_empty,
    input  wire logic                              i_pop,
    output logic                                   o_entry_valid,
    output logic [tsi_pkg::OFFSET_BITS-1:0]        o_entry_offset,
    output logic [63:0]                            o_entry_data,
    output logic                                   o_point_valid,
    output logic [tsi_pkg::OFFSET_BITS-1:0]        o_point_offset,
    output logic [tsi_pkg::PTS_BITS-1:0]           o_point_pts,
    output logic [tsi_pkg::PTS_BITS-1:0]           o_recent_pts,
    output logic                                   o_recent_pts_valid
);
    logic acc, more;
    logic [1:0] st;
    tsi_pkg::t_work w;
    tsi_pkg::t_result res, q;

    assign acc = i_push && !o_full;

    tsi_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(acc), .i_byte(i_stream_byte), .i_offset(i_byte_offset),
        .i_more_set(more), .o_stream_type(st), .o_work(w)
    );
    tsi_scan u_scan (
        .i_clk, .i_rst_n, .i_valid(acc), .i_stream_type(st), .i_work(w),
        .o_more_set(more), .o_result(res)
    );
    tsi_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(acc), .i_data(res), .i_pop,
        .o_full, .o_empty, .o_data(q)
    );

    assign o_entry_valid = q.entry_valid;
    assign o_entry_offset = q.entry_offset;
    assign o_entry_data = q.entry_data;
    assign o_point_valid = q.point_valid;
    assign o_point_offset = q.point_offset;
    assign o_point_pts = q.point_pts;
    assign o_recent_pts = q.recent_pts;
    assign o_recent_pts_valid = q.recent_pts_valid;
endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 6;
    localparam int NUM_PHASES = 5;
    localparam logic [47:0] OFF48 = 48'hFFFF_FFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [13:0] i_cfg_data;
    logic        i_push;
    logic        o_full;
    logic [7:0]  i_stream_byte;
    logic [47:0] i_byte_offset;
    logic        o_empty;
    logic        i_pop;
    logic        o_entry_valid;
    logic [47:0] o_entry_offset;
    logic [63:0] o_entry_data;
    logic        o_point_valid;
    logic [47:0] o_point_offset;
    logic [32:0] o_point_pts;
    logic [32:0] o_recent_pts;
    logic        o_recent_pts_valid;

    ts_start_code_indexer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_push(i_push), .o_full(o_full),
        .i_stream_byte(i_stream_byte), .i_byte_offset(i_byte_offset),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_entry_valid(o_entry_valid), .o_entry_offset(o_entry_offset),
        .o_entry_data(o_entry_data), .o_point_valid(o_point_valid),
        .o_point_offset(o_point_offset), .o_point_pts(o_point_pts),
        .o_recent_pts(o_recent_pts), .o_recent_pts_valid(o_recent_pts_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // indexer shadow: configuration and parse state
    logic [13:0] sel_pid;
    logic [1:0]  sel_stream;
    logic        sel_prefix;
    int          pkt_pos;
    int          sync_fill;
    logic [7:0]  hdr_bytes [4];
    logic        pkt_taken;
    int          pay_begin;
    int          pes_start;
    logic [7:0]  pes_flag_byte;
    logic [32:0] pkt_pts;
    logic        pkt_pts_ok;
    logic [7:0]  win [6];
    logic [47:0] pkt_start;
    logic [32:0] pts_seen;
    logic        pts_seen_ok;
    logic        want_more;
    tsi_pkg::t_result res;

    tsi_pkg::t_result result_q [$];
    int          errors;
    int          n_bytes;
    int          n_entries;
    int          n_points;
    int          idle_cnt;

    function automatic void shadow_restart();
        pkt_pos = 0;
        sync_fill = 0;
    endfunction

    function automatic void shadow_reset();
        sel_pid = 14'd8192;
        sel_stream = 2'd2;
        sel_prefix = 1'b0;
        shadow_restart();
        for (int i = 0; i < 4; i++) hdr_bytes[i] = 8'h00;
        for (int i = 0; i < 6; i++) win[i] = 8'h00;
        pkt_taken = 1'b0;
        pay_begin = tsi_pkg::NO_POS;
        pes_start = tsi_pkg::NO_POS;
        pes_flag_byte = 8'h00;
        pkt_pts = '0;
        pkt_pts_ok = 1'b0;
        pkt_start = '0;
        pts_seen = '0;
        pts_seen_ok = 1'b0;
        want_more = 1'b0;
    endfunction

    function automatic void emit_point();
        res.point_valid = 1'b1;
        res.point_offset = pkt_start;
        res.point_pts = pkt_pts;
    endfunction

    function automatic void emit_entry(int p, int hdr, logic [63:0] data);
        logic [63:0] d;
        d = data;
        if (pkt_pts_ok) d = d | ({31'd0, pkt_pts} << 31) | 64'h100_0000;
        res.entry_valid = 1'b1;
        res.entry_offset = pkt_start + 48'(hdr) + 48'(p);
        res.entry_data = d;
    endfunction

    function automatic void match_code(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2,
                                       logic [7:0] s3, logic [7:0] s4, logic [7:0] s5,
                                       int p, int hdr, bit room6);
        if (s0 != 8'h00 || s1 != 8'h00 || s2 != 8'h01) return;
        if (sel_stream == tsi_pkg::ST_MPEG2) begin
            if (s3 != 8'h00 && s3 != 8'hB3 && s3 != 8'hB8) return;
            if (s3 == 8'hB3 && pkt_pts_ok) emit_point();
            if (!room6) begin
                want_more = 1'b1;
                return;
            end
            emit_entry(p, hdr, {40'd0, s5, s4, s3});
        end else if (sel_stream == tsi_pkg::ST_H264) begin
            if (s3 != 8'h09) return;
            emit_entry(p, hdr, {48'd0, s4, s3});
            if (s4[7:5] == 3'd0 && pkt_pts_ok) emit_point();
        end
    endfunction

    function automatic void mark_payload(int p);
        if (hdr_bytes[1][6]) begin
            pes_start = p;
            pay_begin = tsi_pkg::NO_POS;
        end else begin
            pay_begin = p;
        end
    endfunction

    function automatic void pes_header_byte(int j, logic [7:0] b);
        int d;
        int v;
        d = j - pes_start;
        if (d <= 1) begin
            if (b != 8'h00) pkt_taken = 1'b0;
        end else if (d == 2) begin
            if (b != 8'h01) pkt_taken = 1'b0;
        end else if (d == 7) begin
            pes_flag_byte = b;
        end else if (d == 8) begin
            v = pes_start + 9 + b;
            pay_begin = v > tsi_pkg::NO_POS ? tsi_pkg::NO_POS : v;
        end else if (d >= 9 && d <= 13 && pes_flag_byte[7]) begin
            case (d)
                9: pkt_pts = {b[3:1], 30'd0};
                10: pkt_pts = pkt_pts | (33'(b) << 22);
                11: pkt_pts = pkt_pts | (33'(b[7:1]) << 15);
                12: pkt_pts = pkt_pts | (33'(b) << 7);
                default: begin
                    pkt_pts = pkt_pts | 33'(b[7:1]);
                    pkt_pts_ok = 1'b1;
                    pts_seen = pkt_pts;
                    pts_seen_ok = 1'b1;
                end
            endcase
        end
    endfunction

    function automatic tsi_pkg::t_result index_byte(logic [7:0] b, logic [47:0] off);
        int hdr;
        int psize;
        int k;
        int j;
        int p;
        int ppid;
        bit want;
        hdr = sel_prefix ? 4 : 0;
        psize = 188 + hdr;
        res = '0;
        if (pkt_pos == 0) begin
            if (b == tsi_pkg::SYNC_BYTE && sync_fill >= hdr) begin
                pkt_start = off - 48'(hdr);
                hdr_bytes[0] = b;
                pkt_pos = hdr + 1;
                pkt_taken = 1'b0;
                pay_begin = tsi_pkg::NO_POS;
                pes_start = tsi_pkg::NO_POS;
                pes_flag_byte = 8'h00;
                pkt_pts = '0;
                pkt_pts_ok = 1'b0;
            end else if (sync_fill < 4) begin
                sync_fill++;
            end
        end else begin
            k = pkt_pos;
            j = k >= hdr ? k - hdr : 0;
            for (int i = 0; i < 5; i++) win[i] = win[i+1];
            win[5] = b;
            if (k >= hdr && j <= 3) begin
                hdr_bytes[j] = b;
                if (j == 3) begin
                    ppid = {hdr_bytes[1][4:0], hdr_bytes[2]};
                    want = (ppid == sel_pid) &&
                           (want_more || hdr_bytes[1][6] || sel_stream == tsi_pkg::ST_MPEG2);
                    pkt_taken = 1'b0;
                    if (want) begin
                        want_more = 1'b0;
                        if (b[4] && b[7:6] == 2'b00) begin
                            pkt_taken = 1'b1;
                            if (!b[5]) mark_payload(4);
                        end
                    end
                end
            end else if (k >= hdr && pkt_taken) begin
                if (j == 4 && hdr_bytes[3][5]) begin
                    p = 5 + b;
                    if (p > 188) pkt_taken = 1'b0;
                    else mark_payload(p);
                end else if (hdr_bytes[1][6] && pes_start <= 187 && j >= pes_start) begin
                    pes_header_byte(j, b);
                end
                if (pkt_taken && j >= 5) begin
                    p = j - 5;
                    if (p >= pay_begin && p <= 182)
                        match_code(win[0], win[1], win[2], win[3], win[4], win[5],
                                   p, hdr, 1'b1);
                    if (j == 187 && pay_begin <= 183)
                        match_code(win[1], win[2], win[3], win[4], win[5], 8'h00,
                                   183, hdr, 1'b0);
                end
            end
            if (k + 1 >= psize) shadow_restart();
            else pkt_pos = k + 1;
        end
        res.recent_pts = pts_seen;
        res.recent_pts_valid = pts_seen_ok;
        return res;
    endfunction

    // request driven on the input side, with an optional typed expectation
    logic    drv_typed;
    tsi_pkg::t_result drv_exp;
    bit      no_idle;
    bit      sending;

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        tsi_pkg::t_result got;
        tsi_pkg::t_result want_r;
        tsi_pkg::t_result pred;
        bit moved;
        moved = 1'b0;
        if (i_rst_n && i_push && !o_full) begin
            pred = index_byte(i_stream_byte, i_byte_offset);
            result_q.push_back(drv_typed ? drv_exp : pred);
            n_bytes++;
            moved = 1'b1;
        end
        if (i_rst_n && i_pop && !o_empty) begin
            moved = 1'b1;
            got = '{o_entry_valid, o_entry_offset, o_entry_data, o_point_valid,
                    o_point_offset, o_point_pts, o_recent_pts, o_recent_pts_valid};
            if (result_q.size() == 0) begin
                $display("%0t unexpected result, nothing pending", $time);
                errors++;
            end else begin
                want_r = result_q.pop_front();
                check_field("entry_valid", 64'(want_r.entry_valid), 64'(got.entry_valid));
                check_field("entry_offset", 64'(want_r.entry_offset), 64'(got.entry_offset));
                check_field("entry_data", want_r.entry_data, got.entry_data);
                check_field("point_valid", 64'(want_r.point_valid), 64'(got.point_valid));
                check_field("point_offset", 64'(want_r.point_offset), 64'(got.point_offset));
                check_field("point_pts", 64'(want_r.point_pts), 64'(got.point_pts));
                check_field("recent_pts", 64'(want_r.recent_pts), 64'(got.recent_pts));
                check_field("recent_pts_valid", 64'(want_r.recent_pts_valid),
                            64'(got.recent_pts_valid));
                if (want_r.entry_valid) n_entries++;
                if (want_r.point_valid) n_points++;
            end
        end
        if (moved || !i_rst_n) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no progress, %0d results pending", $time,
                     result_q.size());
            $display("FAIL ts_start_code_indexer");
            $finish;
        end
    end

    initial begin
        i_pop = 1'b0;
        forever begin
            @(negedge i_clk);
            i_pop = no_idle || ($urandom_range(0, 99) >= 17);
        end
    end

    task automatic send_byte(logic [7:0] b, logic [47:0] off, bit typed,
                             tsi_pkg::t_result exp_r);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 17) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        i_push = 1'b1;
        i_stream_byte = b;
        i_byte_offset = off;
        drv_typed = typed;
        drv_exp = exp_r;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        i_push = 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [13:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        if (idx == tsi_pkg::REG_PID) sel_pid = val;
        else if (idx == tsi_pkg::REG_STREAM_TYPE) sel_stream = val[1:0];
        else sel_prefix = val[0];
        shadow_restart();
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    logic [47:0] run_off;

    // packet flavors: 0 plain, 1 huge adaptation field, 2 broken pes start,
    // 3 pes header cut by packet end, 4 start code at last scan position
    task automatic send_packet(int flavor);
        logic [7:0] pkt [192];
        int hdr;
        int idx;
        int n;
        int at;
        logic [12:0] spid;
        logic [1:0]  afc;
        logic [1:0]  scr;
        bit pusi;
        hdr = sel_prefix ? 4 : 0;
        for (int i = 0; i < 192; i++) begin
            case ($urandom_range(0, 3))
                0: pkt[i] = 8'h00;
                1: pkt[i] = 8'h01;
                default: pkt[i] = 8'($urandom);
            endcase
        end
        for (int i = 0; i < hdr; i++) pkt[i] = 8'($urandom);
        spid = (sel_pid <= 14'd8191 && $urandom_range(0, 9) < 8) ? sel_pid[12:0]
                                                                 : 13'($urandom);
        pusi = ($urandom_range(0, 2) != 0) || flavor == 2 || flavor == 3;
        afc = $urandom_range(0, 9) < 6 ? 2'b01 : 2'b11;
        if ($urandom_range(0, 19) == 0) afc = 2'($urandom);
        if (flavor == 1 || flavor == 3) afc = 2'b11;
        scr = $urandom_range(0, 14) == 0 ? 2'($urandom_range(1, 3)) : 2'b00;
        pkt[hdr] = tsi_pkg::SYNC_BYTE;
        pkt[hdr+1] = {1'($urandom), pusi, 1'($urandom), spid[12:8]};
        pkt[hdr+2] = spid[7:0];
        pkt[hdr+3] = {scr, afc, 4'($urandom)};
        idx = hdr + 4;
        if (afc[1]) begin
            n = flavor == 1 ? $urandom_range(184, 255) :
                flavor == 3 ? $urandom_range(172, 182) : $urandom_range(0, 12);
            pkt[idx] = 8'(n);
            idx = idx + 1 + n;
        end
        if (pusi && idx + 14 < hdr + 188) begin
            pkt[idx] = 8'h00;
            pkt[idx+1] = 8'h00;
            pkt[idx+2] = 8'h01;
            pkt[idx+3] = 8'hE0;
            if (flavor == 2) pkt[idx + $urandom_range(0, 2)] = 8'h47;
            pkt[idx+6] = 8'h80;
            pkt[idx+7] = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'h80;
            pkt[idx+8] = $urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 20)) : 8'd5;
            idx = idx + 9 + pkt[idx+8];
        end else if (pusi && flavor == 3) begin
            for (int i = idx; i < hdr + 188; i++)
                pkt[i] = (i - idx) < 3 ? 8'((i - idx) == 2) : 8'h80;
        end
        n = $urandom_range(0, 4);
        for (int c = 0; c < n; c++) begin
            if (idx + 6 >= hdr + 188) break;
            at = $urandom_range(idx, hdr + 182);
            pkt[at] = 8'h00;
            pkt[at+1] = 8'h00;
            pkt[at+2] = 8'h01;
            case ($urandom_range(0, 4))
                0: pkt[at+3] = 8'h00;
                1: pkt[at+3] = 8'hB3;
                2: pkt[at+3] = 8'hB8;
                3: pkt[at+3] = 8'h09;
                default: pkt[at+3] = 8'($urandom);
            endcase
            if ($urandom_range(0, 1)) pkt[at+4] = 8'($urandom_range(0, 31));
        end
        if (flavor == 4) begin
            at = hdr + 183;
            pkt[at] = 8'h00;
            pkt[at+1] = 8'h00;
            pkt[at+2] = 8'h01;
            pkt[at+3] = $urandom_range(0, 1) ? 8'hB3 : 8'h00;
        end
        for (int i = 0; i < hdr + 188; i++) begin
            send_byte(pkt[i], run_off, 1'b0, '0);
            run_off = run_off + 48'd1;
        end
    endtask

    task automatic send_noise(int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (b == tsi_pkg::SYNC_BYTE) b = 8'h48;
            send_byte(b, run_off, 1'b0, '0);
            run_off = run_off + 48'd1;
        end
    endtask

    typedef struct {
        logic [7:0]  b;
        logic [47:0] off;
    } t_row;

    t_row directed [] = '{
        '{8'h00, 48'd0}, '{8'hFF, OFF48}, '{8'hAA, 48'h5555_5555_5555},
        '{8'h55, 48'hAAAA_AAAA_AAAA}, '{8'h47, 48'd4}, '{8'h40, 48'd5},
        '{8'h00, 48'd6}, '{8'h10, 48'd7}, '{8'h00, 48'd8}, '{8'h00, 48'd9},
        '{8'h01, 48'd10}, '{8'hB3, 48'd11}, '{8'h47, OFF48}, '{8'hFF, 48'd0},
        '{8'h01, 48'd1}, '{8'h80, 48'h8000_0000_0000}, '{8'h7F, 48'h7FFF_FFFF_FFFF},
        '{8'h09, 48'd2}, '{8'hB8, 48'd3}, '{8'h00, 48'd4}
    };

    initial begin
        tsi_pkg::t_result zero_r;
        logic [13:0] pv;
        logic [1:0]  sv;
        logic        xv;
        int flavor;
        zero_r = '0;
        errors = 0;
        n_bytes = 0;
        n_entries = 0;
        n_points = 0;
        idle_cnt = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tsi_pkg::REG_PID;
        i_cfg_data = '0;
        i_push = 1'b0;
        i_stream_byte = '0;
        i_byte_offset = '0;
        drv_typed = 1'b0;
        drv_exp = '0;
        shadow_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // nothing selected after reset: every result is all zero
        foreach (directed[i]) send_byte(directed[i].b, directed[i].off, 1'b1, zero_r);
        drv_typed = 1'b0;
        go_quiet();

        run_off = OFF48 - 48'd300;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    pv = 14'h0100; sv = tsi_pkg::ST_MPEG2; xv = 1'b0; flavor = 0;
                end
                1: begin
                    pv = 14'h1FFF; sv = tsi_pkg::ST_H264; xv = 1'b0; flavor = 3;
                end
                2: begin
                    pv = 14'h0000; sv = tsi_pkg::ST_MPEG2; xv = 1'b1; flavor = 4;
                end
                3: begin
                    pv = 14'h3FFF; sv = tsi_pkg::ST_H264; xv = 1'b1; flavor = 1;
                end
                default: begin
                    pv = 14'($urandom_range(0, 8191));
                    sv = 2'($urandom_range(0, 3));
                    xv = 1'($urandom_range(0, 1));
                    flavor = 2;
                end
            endcase
            write_reg(tsi_pkg::REG_PID, pv);
            write_reg(tsi_pkg::REG_STREAM_TYPE, {12'd0, sv});
            write_reg(tsi_pkg::REG_PREFIX, {13'd0, xv});
            no_idle = (ph == NUM_PHASES - 1);
            send_noise($urandom_range(0, 6));
            send_packet(flavor);
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 5));
            no_idle = 1'b0;
            go_quiet();
            if (ph == 1) run_off = 48'($urandom) << 16;
        end

        $display("run covered %0d bytes, %0d structure entries, %0d access points",
                 n_bytes, n_entries, n_points);
        $display("five settings of pid, stream type and prefix, with broken packets");
        if (errors == 0) begin
            $display("PASS ts_start_code_indexer");
        end else begin
            $display("FAIL ts_start_code_indexer");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: ts_start_code_indexer.f
+incdir+rtl
rtl/tsi_pkg.sv
rtl/tsi_front.sv
rtl/tsi_scan.sv
rtl/tsi_fifo.sv
rtl/ts_start_code_indexer.sv
test/tb.sv
